### rtl/chse_pkg.sv
// Shared types and constants for the cubic Hermite segment evaluator.
`timescale 1ns / 1ps
package chse_pkg;

    localparam int POS_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int DIG_W      = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START_POS = 3'd0,
        REG_END_POS   = 3'd1,
        REG_START_VEL = 3'd2,
        REG_END_VEL   = 3'd3,
        REG_DURATION  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic saturated;
        logic time_clamped;
    } t_out_flags;

    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

endpackage

### rtl/chse_div.sv
// Pipelined restoring divider producing the normalized time, one quotient bit per stage.
`timescale 1ns / 1ps
module chse_div
    import chse_pkg::*;
#(
    parameter int TB = 16,
    parameter int SW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [TB-1:0] i_t,
    input  logic [TB-1:0] i_dur,
    input  logic          i_flag,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [SW-1:0] o_s,
    output logic          o_flag
);

    logic          r_v    [SW];
    logic [TB-1:0] r_rem  [SW];
    logic [SW-1:0] r_q    [SW];
    logic          r_f    [SW];
    logic [SW:0]   rdy;

    assign rdy[SW] = i_ready;

    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic          v_in;
        logic [TB:0]   cand;
        logic [SW-1:0] q_in;
        logic          f_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in = i_valid;
            assign cand = {1'b0, i_t};
            assign q_in = '0;
            assign f_in = i_flag;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign cand = {r_rem[k-1], 1'b0};
            assign q_in = r_q[k-1];
            assign f_in = r_f[k-1];
        end

        assign ge      = cand >= {1'b0, i_dur};
        assign rdy[k]  = !r_v[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
            if (rdy[k] && v_in) begin
                r_rem[k] <= ge ? TB'(cand - {1'b0, i_dur}) : TB'(cand);
                r_q[k]   <= {q_in[SW-2:0], ge};
                r_f[k]   <= f_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[SW-1];
    assign o_s     = r_q[SW-1];
    assign o_flag  = r_f[SW-1];

endmodule

### rtl/chse_mul.sv
// Digit-serial pipelined multiply-add: x * s + (addend << shift), one digit of s per stage.
`timescale 1ns / 1ps
module chse_mul
    import chse_pkg::*;
#(
    parameter int XW  = 52,
    parameter int AW  = 52,
    parameter int ASH = 32,
    parameter int SW  = 33,
    parameter int OW  = 86
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic        [SW-1:0] i_s,
    input  logic signed [AW-1:0] i_add,
    input  logic                 i_flag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [OW-1:0] o_p,
    output logic        [SW-1:0] o_s,
    output logic                 o_flag
);

    localparam int ND  = (SW + DIG_W - 1) / DIG_W;
    localparam int SPW = ND * DIG_W;
    localparam int PPW = XW + DIG_W + 1;

    logic                 r_v   [ND];
    logic signed [XW-1:0] r_x   [ND];
    logic        [SW-1:0] r_s   [ND];
    logic signed [OW-1:0] r_acc [ND];
    logic                 r_f   [ND];
    logic [ND:0]          rdy;

    assign rdy[ND] = i_ready;

    for (genvar j = 0; j < ND; j++) begin : g_stage
        logic                  v_in;
        logic signed [XW-1:0]  x_in;
        logic        [SW-1:0]  s_in;
        logic                  f_in;
        logic signed [OW-1:0]  base;
        logic        [SPW-1:0] s_pad;
        logic        [DIG_W-1:0] dig;
        logic signed [PPW-1:0] pp;

        if (j == 0) begin : g_first
            assign v_in = i_valid;
            assign x_in = i_x;
            assign s_in = i_s;
            assign f_in = i_flag;
            assign base = OW'(i_add) <<< ASH;
        end else begin : g_next
            assign v_in = r_v[j-1];
            assign x_in = r_x[j-1];
            assign s_in = r_s[j-1];
            assign f_in = r_f[j-1];
            assign base = r_acc[j-1];
        end

        assign s_pad  = SPW'(s_in);
        assign dig    = s_pad[j*DIG_W +: DIG_W];
        assign pp     = x_in * $signed({1'b0, dig});
        assign rdy[j] = !r_v[j] || rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= v_in;
            end
            if (rdy[j] && v_in) begin
                r_x[j]   <= x_in;
                r_s[j]   <= s_in;
                r_f[j]   <= f_in;
                r_acc[j] <= base + (OW'(pp) <<< (j * DIG_W));
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[ND-1];
    assign o_p     = r_acc[ND-1];
    assign o_s     = r_s[ND-1];
    assign o_flag  = r_f[ND-1];

endmodule

### rtl/cubic_hermite_segment_eval_core.sv
// Top level of the cubic Hermite segment evaluator.
//
// Usage: write the segment (start/end position, start/end velocity, duration)
// through the cfg channel while the stream is idle; register index 0..4 in
// the order start_pos, end_pos, start_vel, end_vel, duration_ms. The cfg
// channel is always ready; writes to other indexes are dropped.
// Each time sample transferred on the slave stream gives one position on the
// master stream, in order, rounded and saturated to Q16.16 with flags.
// Pipeline: 1 + (FRAC_BITS + 1) + 3 * ceil((FRAC_BITS + 1) / 8) + 2 register
// stages (51 at the defaults): input clamp stage, one divider stage per
// quotient bit, three Horner multiply-adds of one 8-bit digit per stage, then
// the magnitude and round/saturate stages.
// Throughput: one sample per cycle while the receiver does not stall. Every stage holds its own valid bit, so
// when the receiver stalls the result waits in the output register while
// empty stages upstream keep filling; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module cubic_hermite_segment_eval_core
    import chse_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int FRAC_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]              i_cfg_addr,
    input  logic [31:0]                        i_cfg_wdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // bits: time_ms, zero padding
    input  logic [((TIME_BITS+7)/8)*8-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // bits: position
    output logic [POS_W-1:0]                   o_m_tdata,
    // bits: time_clamped, saturated
    output logic [1:0]                         o_m_tuser
);

    localparam int TB = TIME_BITS;
    localparam int F  = FRAC_BITS;
    localparam int SW = F + 1;
    localparam int CW = TB + 36;
    localparam int W1 = CW + F + 2;
    localparam int W2 = W1 + F + 2;
    localparam int W3 = W2 + F + 2;
    localparam int RW = W3 + 1 - 3 * F;

    logic signed [31:0]   r_start_pos, r_end_pos, r_start_vel, r_end_vel;
    logic        [TB-1:0] r_duration;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_end_pos   <= '0;
            r_start_vel <= '0;
            r_end_vel   <= '0;
            r_duration  <= TB'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                REG_START_POS: r_start_pos <= i_cfg_wdata;
                REG_END_POS:   r_end_pos   <= i_cfg_wdata;
                REG_START_VEL: r_start_vel <= i_cfg_wdata;
                REG_END_VEL:   r_end_vel   <= i_cfg_wdata;
                REG_DURATION:  r_duration  <= TB'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    logic        [TB-1:0] dur_eff;
    logic signed [TB:0]   ti;
    logic signed [32:0]   vsum_a;
    logic signed [33:0]   vsum_b;
    logic signed [TB+33:0] prod_a;
    logic signed [TB+34:0] prod_b;
    logic signed [TB+32:0] prod_c;
    logic signed [CW-1:0] dq;
    logic signed [CW-1:0] n_coef_a, n_coef_b, n_coef_c;
    logic signed [CW-1:0] r_coef_a, r_coef_b, r_coef_c;

    assign dur_eff  = (r_duration == '0) ? TB'(1) : r_duration;
    assign ti       = $signed({1'b0, dur_eff});
    assign vsum_a   = 33'(r_start_vel) + 33'(r_end_vel);
    assign vsum_b   = (34'(r_start_vel) <<< 1) + 34'(r_end_vel);
    assign prod_a   = ti * vsum_a;
    assign prod_b   = ti * vsum_b;
    assign prod_c   = ti * r_start_vel;
    assign dq       = CW'(r_end_pos) - CW'(r_start_pos);
    assign n_coef_a = CW'(prod_a) - (dq <<< 1);
    assign n_coef_b = (dq <<< 1) + dq - CW'(prod_b);
    assign n_coef_c = CW'(prod_c);

    always_ff @(posedge i_clk) begin
        r_coef_a <= n_coef_a;
        r_coef_b <= n_coef_b;
        r_coef_c <= n_coef_c;
    end

    logic          r_in_v;
    logic [TB-1:0] r_in_t;
    logic          r_in_clamp;
    logic [TB-1:0] t_in;
    logic          in_ready;
    logic          div_ready;

    assign t_in       = i_s_tdata[TB-1:0];
    assign in_ready   = !r_in_v || div_ready;
    assign o_s_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_ready) begin
            r_in_v <= i_s_tvalid;
        end
        if (in_ready && i_s_tvalid) begin
            r_in_clamp <= t_in > dur_eff;
            r_in_t     <= (t_in > dur_eff) ? dur_eff : t_in;
        end
    end

    logic          div_valid, m1_ready;
    logic [SW-1:0] div_s;
    logic          div_flag;

    chse_div #(.TB(TB), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .o_ready (div_ready),
        .i_t     (r_in_t),
        .i_dur   (dur_eff),
        .i_flag  (r_in_clamp),
        .o_valid (div_valid),
        .i_ready (m1_ready),
        .o_s     (div_s),
        .o_flag  (div_flag)
    );

    logic                 m1_valid, m2_ready, m2_valid, m3_ready, m3_valid, r1_ready;
    logic signed [W1-1:0] m1_p;
    logic signed [W2-1:0] m2_p;
    logic signed [W3-1:0] m3_p;
    logic [SW-1:0]        m1_s, m2_s;
    logic                 m1_flag, m2_flag, m3_flag;

    chse_mul #(.XW(CW), .AW(CW), .ASH(F), .SW(SW), .OW(W1)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (m1_ready),
        .i_x     (r_coef_a),
        .i_s     (div_s),
        .i_add   (r_coef_b),
        .i_flag  (div_flag),
        .o_valid (m1_valid),
        .i_ready (m2_ready),
        .o_p     (m1_p),
        .o_s     (m1_s),
        .o_flag  (m1_flag)
    );

    chse_mul #(.XW(W1), .AW(CW), .ASH(2 * F), .SW(SW), .OW(W2)) u_mul2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m1_valid),
        .o_ready (m2_ready),
        .i_x     (m1_p),
        .i_s     (m1_s),
        .i_add   (r_coef_c),
        .i_flag  (m1_flag),
        .o_valid (m2_valid),
        .i_ready (m3_ready),
        .o_p     (m2_p),
        .o_s     (m2_s),
        .o_flag  (m2_flag)
    );

    chse_mul #(.XW(W2), .AW(32), .ASH(3 * F), .SW(SW), .OW(W3)) u_mul3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m2_valid),
        .o_ready (m3_ready),
        .i_x     (m2_p),
        .i_s     (m2_s),
        .i_add   (r_start_pos),
        .i_flag  (m2_flag),
        .o_valid (m3_valid),
        .i_ready (r1_ready),
        .o_p     (m3_p),
        .o_s     (),
        .o_flag  (m3_flag)
    );

    logic          r_r1_v, r_r1_neg, r_r1_clamp;
    logic [W3-1:0] r_r1_mag;
    logic          out_ready;

    assign r1_ready = !r_r1_v || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_v <= 1'b0;
        end else if (r1_ready) begin
            r_r1_v <= m3_valid;
        end
        if (r1_ready && m3_valid) begin
            r_r1_neg   <= m3_p[W3-1];
            r_r1_mag   <= m3_p[W3-1] ? W3'(-m3_p) : W3'(m3_p);
            r_r1_clamp <= m3_flag;
        end
    end

    logic [W3:0]      rsum;
    logic [RW-1:0]    rnd;
    logic             sat;
    logic [POS_W-1:0] n_pos;
    logic             r_out_v;
    logic [POS_W-1:0] r_out_pos;
    t_out_flags       r_out_flags;

    assign out_ready = !r_out_v || i_m_tready;
    assign rsum = {1'b0, r_r1_mag} + ((W3 + 1)'(1) << (3 * F - 1));
    assign rnd  = RW'(rsum >> (3 * F));
    assign sat  = r_r1_neg ? (rnd > RW'(POS_MIN)) : (rnd > RW'(POS_MAX));
    assign n_pos = sat ? (r_r1_neg ? POS_MIN : POS_MAX)
                       : (r_r1_neg ? POS_W'(-rnd[POS_W-1:0]) : rnd[POS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= r_r1_v;
        end
        if (out_ready && r_r1_v) begin
            r_out_pos                <= n_pos;
            r_out_flags.saturated    <= sat;
            r_out_flags.time_clamped <= r_r1_clamp;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_pos;
    assign o_m_tuser  = r_out_flags;

    a_clamp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (t_in > dur_eff)) |=> (r_in_v && r_in_clamp))
        else $error("clamped sample not marked in input stage");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_in_clamp) |-> (r_in_t == dur_eff))
        else $error("clamped time differs from duration");

    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> (div_s <= (SW'(1) << F)))
        else $error("normalized time above one");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> ((o_m_tdata == POS_MAX) || (o_m_tdata == POS_MIN)))
        else $error("saturated flag with unsaturated position");

endmodule

### sim/cubic_hermite_segment_eval_core_test.sv
// Self-checking testbench for the cubic Hermite segment evaluator core.
`timescale 1ns / 1ps
module cubic_hermite_segment_eval_core_test;
    import chse_pkg::*;

    localparam int                    DRAIN_CYCLES = 60;
    localparam int                    CYCLE_LIMIT  = 400000;
    localparam int                    RAND_PHASES  = 10;
    localparam int                    PHASE_ITEMS  = 95;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED   = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             clamped;
        logic             sat;
    } t_position;

    typedef enum logic { ROW_CFG, ROW_ITEM } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           data;
        logic [15:0]           time_ms;
        logic                  has_lit;
        t_position             lit;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [31:0]           i_cfg_wdata;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [15:0]           i_s_tdata;    // bits: time_ms
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [POS_W-1:0]      o_m_tdata;    // bits: position
    logic [1:0]            o_m_tuser;    // bits: time_clamped, saturated

    logic [31:0] seg_q0, seg_q1, seg_v0, seg_v1;
    logic [15:0] seg_dur;
    t_position   position_q[$];
    t_position   literal_q[$];
    int          mismatches;
    int          cycles = 0;
    logic        stall_on;

    cubic_hermite_segment_eval_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_position hermite_position(logic [15:0] t_in);
        t_position           r;
        logic [15:0]         dur;
        logic [15:0]         tt;
        logic [32:0]         s;
        logic signed [63:0]  q0, q1, v0, v1, ti, a, b, c;
        logic signed [255:0] acc, ss, bw, cw, qw;
        logic [255:0]        mag;
        logic                neg;
        dur = (seg_dur == 16'd0) ? 16'd1 : seg_dur;
        r.clamped = t_in > dur;
        tt = r.clamped ? dur : t_in;
        s = 33'({tt, 32'b0} / dur);
        q0 = $signed(seg_q0);
        q1 = $signed(seg_q1);
        v0 = $signed(seg_v0);
        v1 = $signed(seg_v1);
        ti = {48'b0, dur};
        a = 2 * (q0 - q1) + ti * (v0 + v1);
        b = 3 * (q1 - q0) - ti * (2 * v0 + v1);
        c = ti * v0;
        ss = 256'(s);
        bw = 256'(b);
        cw = 256'(c);
        qw = 256'(q0);
        acc = 256'(a);
        acc = acc * ss + (bw <<< 32);
        acc = acc * ss + (cw <<< 64);
        acc = acc * ss + (qw <<< 96);
        neg = acc[255];
        mag = neg ? -acc : acc;
        mag = (mag + (256'd1 << 95)) >> 96;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 256'h8000_0000) begin
                r.sat = 1'b1;
                r.pos = POS_MIN;
            end else begin
                r.pos = -mag[31:0];
            end
        end else begin
            if (mag > 256'h7FFF_FFFF) begin
                r.sat = 1'b1;
                r.pos = POS_MAX;
            end else begin
                r.pos = mag[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_position want;
        t_position got;
        if (!i_rst_n) begin
            seg_q0  <= '0;
            seg_q1  <= '0;
            seg_v0  <= '0;
            seg_v1  <= '0;
            seg_dur <= 16'd1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_START_POS: seg_q0  <= i_cfg_wdata;
                    REG_END_POS:   seg_q1  <= i_cfg_wdata;
                    REG_START_VEL: seg_v0  <= i_cfg_wdata;
                    REG_END_VEL:   seg_v1  <= i_cfg_wdata;
                    REG_DURATION:  seg_dur <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                if (literal_q.size() > 0) position_q.push_back(literal_q.pop_front());
                else position_q.push_back(hermite_position(i_s_tdata));
            end
            if (o_m_tvalid && i_m_tready) begin
                got.pos     = o_m_tdata;
                got.clamped = o_m_tuser[0];
                got.sat     = o_m_tuser[1];
                if (position_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pos=%h flags=%b", o_m_tdata, o_m_tuser);
                end else begin
                    want = position_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp pos=%h clamp=%b sat=%b got pos=%h clamp=%b sat=%b",
                                     want.pos, want.clamped, want.sat,
                                     got.pos, got.clamped, got.sat);
                    end
                end
            end
        end
    end

    always @(negedge i_clk)
        i_m_tready <= !stall_on || ($urandom_range(99) >= 31);

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_time(logic [15:0] t);
        while (stall_on && $urandom_range(99) < 31) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = t;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_stream();
        i_s_tvalid = 1'b0;
        while (position_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(9))
            0: return 32'd1;
            1: return 32'd65535;
            2: return 32'd0;
            3, 4: return $urandom;
            default: return $urandom_range(200, 1);
        endcase
    endfunction

    function automatic t_row cfg_row(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        t_row r;
        r = '{kind: ROW_CFG, addr: addr, data: data, time_ms: '0, has_lit: 1'b0, lit: '0};
        return r;
    endfunction

    function automatic t_row item_row(logic [15:0] t, logic has_lit, t_position lit);
        t_row r;
        r = '{kind: ROW_ITEM, addr: '0, data: '0, time_ms: t, has_lit: has_lit, lit: lit};
        return r;
    endfunction

    initial begin
        t_row        rows[$];
        logic [15:0] dur;
        logic        need_drain;
        mismatches  = 0;
        stall_on    = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;

        // reset segment: all zero, duration one
        rows.push_back(item_row(16'd0,     1'b1, '{32'd0, 1'b0, 1'b0}));
        rows.push_back(item_row(16'd1,     1'b1, '{32'd0, 1'b0, 1'b0}));
        rows.push_back(item_row(16'd2,     1'b1, '{32'd0, 1'b1, 1'b0}));
        rows.push_back(item_row(16'hFFFF,  1'b1, '{32'd0, 1'b1, 1'b0}));
        // full position span, longest duration
        rows.push_back(cfg_row(REG_START_POS, POS_MIN));
        rows.push_back(cfg_row(REG_END_POS,   POS_MAX));
        rows.push_back(cfg_row(REG_DURATION,  32'd65535));
        rows.push_back(item_row(16'd0,     1'b1, '{POS_MIN, 1'b0, 1'b0}));
        rows.push_back(item_row(16'hFFFF,  1'b1, '{POS_MAX, 1'b0, 1'b0}));
        rows.push_back(item_row(16'd32768, 1'b0, '0));
        rows.push_back(item_row(16'd65534, 1'b0, '0));
        // extreme velocities force saturation
        rows.push_back(cfg_row(REG_START_POS, 32'd0));
        rows.push_back(cfg_row(REG_END_POS,   32'd0));
        rows.push_back(cfg_row(REG_START_VEL, POS_MAX));
        rows.push_back(cfg_row(REG_END_VEL,   POS_MAX));
        rows.push_back(item_row(16'd0,     1'b1, '{32'd0, 1'b0, 1'b0}));
        rows.push_back(item_row(16'd16384, 1'b0, '0));
        rows.push_back(item_row(16'd49151, 1'b0, '0));
        // negative velocities, short segment, zero duration, unused index
        rows.push_back(cfg_row(REG_START_VEL, POS_MIN));
        rows.push_back(cfg_row(REG_END_VEL,   POS_MIN));
        rows.push_back(cfg_row(REG_DURATION,  32'd1000));
        rows.push_back(item_row(16'd500,   1'b0, '0));
        rows.push_back(item_row(16'd1001,  1'b0, '0));
        rows.push_back(cfg_row(REG_DURATION,  32'd0));
        rows.push_back(cfg_row(REG_UNUSED,    32'h1234_5678));
        rows.push_back(item_row(16'd1,     1'b0, '0));
        rows.push_back(item_row(16'd7,     1'b0, '0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        need_drain = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                if (need_drain) drain_stream();
                need_drain = 1'b0;
                write_reg(rows[i].addr, rows[i].data);
            end else begin
                if (rows[i].has_lit) literal_q.push_back(rows[i].lit);
                send_time(rows[i].time_ms);
                need_drain = 1'b1;
            end
        end
        drain_stream();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            stall_on = !(ph == 3 || ph == 4);
            write_reg(REG_START_POS, pick_word());
            write_reg(REG_END_POS,   pick_word());
            write_reg(REG_START_VEL, pick_word());
            write_reg(REG_END_VEL,   pick_word());
            write_reg(REG_DURATION,  pick_duration());
            if ($urandom_range(3) == 0) write_reg(REG_UNUSED + 3'($urandom_range(2)), $urandom);
            @(negedge i_clk);
            dur = (seg_dur == 16'd0) ? 16'd1 : seg_dur;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9) < 7) send_time(16'($urandom_range(dur)));
                else send_time(16'($urandom));
            end
            drain_stream();
        end

        if (mismatches == 0 && position_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### cubic_hermite_segment_eval_core.f
rtl/chse_pkg.sv
rtl/chse_div.sv
rtl/chse_mul.sv
rtl/cubic_hermite_segment_eval_core.sv
sim/cubic_hermite_segment_eval_core_test.sv
